[sv/rst2d_pkg.sv]
// ----------------------------------------------------------------------------
// rst2d_pkg
// Shared widths, field offsets, item kinds and index helpers for the
// two-dimensional range sum tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rst2d_pkg;

    localparam int COORD_W   = 9;
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 64;
    localparam int WALK_W    = 11;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    localparam int COL_LOW_LSB  = 0;
    localparam int ROW_LOW_LSB  = 9;
    localparam int COL_HIGH_LSB = 18;
    localparam int ROW_HIGH_LSB = 27;
    localparam int VALUE_LSB    = 36;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [WALK_W-1:0] walk_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic                      kind;
        logic [COORD_W-1:0]        col_low;
        logic [COORD_W-1:0]        row_low;
        logic [COORD_W-1:0]        col_high;
        logic [COORD_W-1:0]        row_high;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    function automatic walk_t low_bit(input walk_t x);
        return x & (~x + 1'b1);
    endfunction

endpackage

`default_nettype wire

[sv/range_sum_tree_2d_unit.sv]
// ----------------------------------------------------------------------------
// range_sum_tree_2d_unit
// Two-dimensional binary indexed tree of 64-bit wrapping sums held in one
// synchronous memory; point adds and rectangle sum queries.
// ----------------------------------------------------------------------------
// steps: an add reads and writes back each touched tree entry, at most
//   (clog2(SIDE)+1)^2 entries; a query issues one memory read per cycle over
//   four prefix walks, then offers its result
// throughput: one item at a time, set by the single memory port
// reset: aresetn clears the control state, then a clearing pass writes zero
//   to all 2^(2*clog2(SIDE)) entries, one a cycle, with s_tready held low
`default_nettype none

module range_sum_tree_2d_unit #(
    parameter int SIDE = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // col_low[8:0], row_low[17:9], col_high[26:18], row_high[35:27], value[67:36]
    input  wire logic [rst2d_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // rect_sum[63:0]
    output logic [rst2d_pkg::M_TDATA_W-1:0]      m_tdata,
    // range_error[0]
    output logic [0:0]                           m_tuser
);

    localparam int IDX_W     = $clog2(SIDE);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam rst2d_pkg::walk_t SIDE_W = rst2d_pkg::WALK_W'(SIDE);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADD_RD = 3'd2;
    localparam logic [2:0] ST_ADD_WR = 3'd3;
    localparam logic [2:0] ST_QUERY  = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    rst2d_pkg::item_t in_item;

    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    rst2d_pkg::walk_t        i_reg, i_next;
    rst2d_pkg::walk_t        j_reg, j_next;
    rst2d_pkg::walk_t        cl_reg, cl_next;
    rst2d_pkg::walk_t        rl_reg, rl_next;
    rst2d_pkg::walk_t        ch_reg, ch_next;
    rst2d_pkg::walk_t        rh_reg, rh_next;
    rst2d_pkg::sum_t         value_reg, value_next;
    logic [1:0]              q_reg, q_next;
    rst2d_pkg::sum_t         acc_reg, acc_next;
    logic                    err_reg, err_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    rd_neg_reg, rd_neg_next;
    logic                    out_valid_reg, out_valid_next;
    rst2d_pkg::sum_t         out_sum_reg, out_sum_next;
    logic                    out_err_reg, out_err_next;

    logic [rst2d_pkg::SUM_W-1:0] mem [MEM_DEPTH];
    rst2d_pkg::sum_t         mem_rd_data_reg;
    logic                    mem_re;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_addr;
    rst2d_pkg::sum_t         mem_wr_data;

    rst2d_pkg::walk_t        i_m1, j_m1;
    rst2d_pkg::walk_t        i_dn, j_dn, i_up, j_up;
    rst2d_pkg::walk_t        x_cl, x_rl, x_ch, x_rh;
    logic                    in_accept;
    logic                    cl_ok, rl_ok, ch_ok, rh_ok;
    logic                    walk_active;
    rst2d_pkg::sum_t         rd_term;

    assign in_item = {s_tuser[0],
                      s_tdata[rst2d_pkg::COL_LOW_LSB  +: rst2d_pkg::COORD_W],
                      s_tdata[rst2d_pkg::ROW_LOW_LSB  +: rst2d_pkg::COORD_W],
                      s_tdata[rst2d_pkg::COL_HIGH_LSB +: rst2d_pkg::COORD_W],
                      s_tdata[rst2d_pkg::ROW_HIGH_LSB +: rst2d_pkg::COORD_W],
                      s_tdata[rst2d_pkg::VALUE_LSB    +: rst2d_pkg::VALUE_W]};

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_sum_reg;
    assign m_tuser   = out_err_reg;

    assign x_cl = rst2d_pkg::WALK_W'(in_item.col_low);
    assign x_rl = rst2d_pkg::WALK_W'(in_item.row_low);
    assign x_ch = rst2d_pkg::WALK_W'(in_item.col_high);
    assign x_rh = rst2d_pkg::WALK_W'(in_item.row_high);
    assign cl_ok = (x_cl != '0) && (x_cl <= SIDE_W);
    assign rl_ok = (x_rl != '0) && (x_rl <= SIDE_W);
    assign ch_ok = (x_ch != '0) && (x_ch <= SIDE_W);
    assign rh_ok = (x_rh != '0) && (x_rh <= SIDE_W);

    assign i_m1 = i_reg - 1'b1;
    assign j_m1 = j_reg - 1'b1;
    assign i_dn = i_reg - rst2d_pkg::low_bit(i_reg);
    assign j_dn = j_reg - rst2d_pkg::low_bit(j_reg);
    assign i_up = i_reg + rst2d_pkg::low_bit(i_reg);
    assign j_up = j_reg + rst2d_pkg::low_bit(j_reg);
    assign walk_active = (i_reg != '0) && (j_reg != '0);

    assign rd_term  = rd_neg_reg ? (~mem_rd_data_reg + 1'b1) : mem_rd_data_reg;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cl_next        = cl_reg;
        rl_next        = rl_reg;
        ch_next        = ch_reg;
        rh_next        = rh_reg;
        value_next     = value_reg;
        q_next         = q_reg;
        err_next       = err_reg;
        rd_valid_next  = 1'b0;
        rd_neg_next    = q_reg[0] ^ q_reg[1];
        acc_next       = rd_valid_reg ? (acc_reg + rd_term) : acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_sum_next   = out_sum_reg;
        out_err_next   = out_err_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = {i_m1[IDX_W-1:0], j_m1[IDX_W-1:0]};
        mem_wr_data    = mem_rd_data_reg + value_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wr_data   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    cl_next    = x_cl;
                    rl_next    = x_rl;
                    ch_next    = x_ch;
                    rh_next    = x_rh;
                    value_next = {{(rst2d_pkg::SUM_W-rst2d_pkg::VALUE_W){in_item.value[31]}},
                                  in_item.value};
                    q_next     = 2'd0;
                    acc_next   = '0;
                    err_next   = 1'b0;
                    if (in_item.kind == rst2d_pkg::KIND_ADD) begin
                        if (cl_ok && rl_ok) begin
                            i_next     = x_rl;
                            j_next     = x_cl;
                            state_next = ST_ADD_RD;
                        end
                    end else if (cl_ok && rl_ok && ch_ok && rh_ok) begin
                        i_next     = x_rh;
                        j_next     = x_ch;
                        state_next = ST_QUERY;
                    end else begin
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_ADD_RD: begin
                mem_re     = 1'b1;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                mem_we = 1'b1;
                if (j_up <= SIDE_W) begin
                    j_next     = j_up;
                    state_next = ST_ADD_RD;
                end else if (i_up <= SIDE_W) begin
                    i_next     = i_up;
                    j_next     = cl_reg;
                    state_next = ST_ADD_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_QUERY: begin
                mem_re        = walk_active;
                rd_valid_next = walk_active;
                if (walk_active && (j_dn != '0)) begin
                    j_next = j_dn;
                end else if (walk_active && (i_dn != '0)) begin
                    i_next = i_dn;
                    case (q_reg)
                        2'd0, 2'd2: j_next = ch_reg;
                        default:    j_next = cl_reg - 1'b1;
                    endcase
                end else if (q_reg == 2'd3) begin
                    state_next = ST_FIN;
                end else begin
                    q_next = q_reg + 1'b1;
                    case (q_reg)
                        2'd0: begin
                            i_next = rh_reg;
                            j_next = cl_reg - 1'b1;
                        end
                        2'd1: begin
                            i_next = rl_reg - 1'b1;
                            j_next = ch_reg;
                        end
                        default: begin
                            i_next = rl_reg - 1'b1;
                            j_next = cl_reg - 1'b1;
                        end
                    endcase
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_sum_next   = err_reg ? '0 : acc_next;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        cl_reg      <= cl_next;
        rl_reg      <= rl_next;
        ch_reg      <= ch_next;
        rh_reg      <= rh_next;
        value_reg   <= value_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        rd_neg_reg  <= rd_neg_next;
        out_sum_reg <= out_sum_next;
        out_err_reg <= out_err_next;
    end

    // tree store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wr_data;
        end
        if (mem_re) begin
            mem_rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

[sv/rst2d_checker.sv]
// ----------------------------------------------------------------------------
// rst2d_checker
// Port-level checks for the two-dimensional range sum tree, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rst2d_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [0:0]                      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rst2d_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]                      m_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an out-of-range query carries a zero sum
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("range error with nonzero sum");

    // the store is being cleared right after reset
    a_clear_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready during clearing pass");

    // no new transfer while a query result is being assembled
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == rst2d_pkg::KIND_QUERY |=> !s_tready)
        else $error("second transfer taken during a query");

endmodule

bind range_sum_tree_2d_unit rst2d_checker u_rst2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/range_sum_tree_2d_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_sum_tree_2d_unit_tb
// Drives point adds and rectangle queries into the 2D range sum tree with
// bursty input and a stalling result side. A local copy of the tree predicts
// each query result, which is checked against the transfers seen on m_.
// ----------------------------------------------------------------------------

module range_sum_tree_2d_unit_tb;

    localparam int GRID_SIDE   = 256;
    localparam int RAND_ITEMS  = 1200;
    localparam int IDLE_LIMIT  = 200000;
    localparam int SETTLE_CYC  = 400;
    localparam int SHOW_MAX    = 10;

    typedef struct {
        rst2d_pkg::item_t item;
        bit               drain;
    } stim_t;

    typedef struct {
        rst2d_pkg::sum_t sum;
        logic            err;
    } query_res_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rst2d_pkg::S_TDATA_W-1:0] s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rst2d_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;

    rst2d_pkg::sum_t grid_tree [0:GRID_SIDE*GRID_SIDE-1];
    stim_t           stim_q[$];
    query_res_t      pending_sums[$];

    bit in_flight;
    int gap_left;
    int burst_left;
    int stall_mode;
    int cycle_cnt;
    int idle_cnt;
    int fail_count;

    range_sum_tree_2d_unit #(
        .SIDE(GRID_SIDE)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit on_grid(input int i);
        return i >= 1 && i <= GRID_SIDE;
    endfunction

    // prefix over rows 1..r and columns 1..c
    function automatic rst2d_pkg::sum_t corner_sum(input int c, input int r);
        rst2d_pkg::sum_t acc;
        int              i;
        int              j;
        acc = '0;
        for (i = r; i > 0; i -= i & -i)
            for (j = c; j > 0; j -= j & -j)
                acc += grid_tree[(i - 1) * GRID_SIDE + (j - 1)];
        return acc;
    endfunction

    // update the local tree and queue the result a query produces
    function automatic void track_item(input rst2d_pkg::item_t it);
        int              cl;
        int              rl;
        int              ch;
        int              rh;
        int              i;
        int              j;
        rst2d_pkg::sum_t delta;
        query_res_t      res;
        cl = it.col_low;
        rl = it.row_low;
        ch = it.col_high;
        rh = it.row_high;
        delta = {{(rst2d_pkg::SUM_W - rst2d_pkg::VALUE_W){it.value[rst2d_pkg::VALUE_W-1]}},
                 it.value};
        if (it.kind == rst2d_pkg::KIND_ADD) begin
            if (on_grid(cl) && on_grid(rl))
                for (i = rl; i <= GRID_SIDE; i += i & -i)
                    for (j = cl; j <= GRID_SIDE; j += j & -j)
                        grid_tree[(i - 1) * GRID_SIDE + (j - 1)] += delta;
        end else begin
            if (!on_grid(cl) || !on_grid(rl) || !on_grid(ch) || !on_grid(rh)) begin
                res.sum = '0;
                res.err = 1'b1;
            end else begin
                res.sum = corner_sum(ch, rh) - corner_sum(cl - 1, rh)
                        - corner_sum(ch, rl - 1) + corner_sum(cl - 1, rl - 1);
                res.err = 1'b0;
            end
            pending_sums.push_back(res);
        end
    endfunction

    function automatic void queue_item(input logic kind, input int cl, input int rl,
                                       input int ch, input int rh, input logic [31:0] v,
                                       input bit drain);
        stim_t s;
        s.item.kind     = kind;
        s.item.col_low  = cl[rst2d_pkg::COORD_W-1:0];
        s.item.row_low  = rl[rst2d_pkg::COORD_W-1:0];
        s.item.col_high = ch[rst2d_pkg::COORD_W-1:0];
        s.item.row_high = rh[rst2d_pkg::COORD_W-1:0];
        s.item.value    = v;
        s.drain         = drain;
        stim_q.push_back(s);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // in-range coordinate in 1..span; a small span clusters points so that queries see real sums
    function automatic int pick_coord(input int span);
        return $urandom_range(1, span);
    endfunction

    // accept side, prediction and result check
    always @(posedge aclk) begin
        query_res_t want;
        stim_t      got;
        bit         moved;
        moved = 1'b0;
        cycle_cnt++;
        if (s_tvalid && s_tready) begin
            got = stim_q.pop_front();
            track_item(got.item);
            in_flight = 1'b0;
            moved = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        if (m_tvalid && m_tready) begin
            moved = 1'b1;
            if (pending_sums.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_MAX)
                    $display("unexpected result transfer: sum %h err %b", m_tdata, m_tuser);
            end else begin
                want = pending_sums.pop_front();
                if (m_tdata !== want.sum || m_tuser[0] !== want.err) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("mismatch: sum exp %h got %h, err exp %b got %b",
                                 want.sum, m_tdata, want.err, m_tuser);
                end
            end
        end
        idle_cnt = moved ? 0 : idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("range_sum_tree_2d_unit_tb NOT OK");
            $finish;
        end
    end

    // drive side
    always @(negedge aclk) begin
        stim_t                           head;
        logic [rst2d_pkg::S_TDATA_W-1:0] word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!in_flight) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() != 0
                             && !(stim_q[0].drain && pending_sums.size() != 0)) begin
                    head = stim_q[0];
                    word = '0;
                    word[rst2d_pkg::COL_LOW_LSB  +: rst2d_pkg::COORD_W] = head.item.col_low;
                    word[rst2d_pkg::ROW_LOW_LSB  +: rst2d_pkg::COORD_W] = head.item.row_low;
                    word[rst2d_pkg::COL_HIGH_LSB +: rst2d_pkg::COORD_W] = head.item.col_high;
                    word[rst2d_pkg::ROW_HIGH_LSB +: rst2d_pkg::COORD_W] = head.item.row_high;
                    word[rst2d_pkg::VALUE_LSB    +: rst2d_pkg::VALUE_W] = head.item.value;
                    s_tdata  <= word;
                    s_tuser  <= head.item.kind;
                    s_tvalid <= 1'b1;
                    in_flight = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (cycle_cnt % 50 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (cycle_cnt % 8 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        int          n;
        int          roll;
        int          span;
        int          a;
        int          b;
        int          c;
        int          d;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        aresetn    = 1'b0;
        in_flight  = 1'b0;
        gap_left   = 0;
        burst_left = 8;
        stall_mode = 0;
        cycle_cnt  = 0;
        idle_cnt   = 0;
        fail_count = 0;
        for (n = 0; n < GRID_SIDE * GRID_SIDE; n++)
            grid_tree[n] = '0;

        // corners with extreme values, dropped adds, then queries
        queue_item(rst2d_pkg::KIND_ADD, 1, 1, 0, 0, 32'd5, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 256, 256, 511, 511, 32'h7fff_ffff, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 1, 256, 0, 0, 32'h8000_0000, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 256, 1, 0, 0, 32'hffff_ffff, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 0, 5, 3, 3, 32'd100, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 257, 3, 3, 3, 32'd7, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 9, 511, 511, 511, 32'hffff_ffff, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 128, 128, 0, 0, 32'h5555_5555, 1'b0);
        queue_item(rst2d_pkg::KIND_ADD, 127, 129, 0, 0, 32'haaaa_aaaa, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 1, 1, 256, 256, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 1, 1, 1, 1, 32'hffff_ffff, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 256, 256, 256, 256, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 200, 1, 3, 256, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 1, 256, 256, 1, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 0, 1, 256, 256, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 1, 511, 256, 256, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 1, 1, 257, 256, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 1, 1, 256, 0, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 511, 511, 511, 511, 32'hffff_ffff, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 100, 100, 200, 200, 32'd0, 1'b0);
        queue_item(rst2d_pkg::KIND_QUERY, 127, 127, 128, 129, 32'd0, 1'b0);

        for (n = 0; n < RAND_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            span = ($urandom_range(0, 2) == 0) ? GRID_SIDE : 16;
            if (roll < 10) begin
                // noise over the whole field range
                queue_item(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom, n % 300 == 0);
            end else if (roll < 60) begin
                queue_item(rst2d_pkg::KIND_ADD, pick_coord(span), pick_coord(span),
                           $urandom_range(0, 511), $urandom_range(0, 511),
                           pick_value(), n % 300 == 0);
            end else begin
                a = pick_coord(span);
                b = pick_coord(span);
                c = pick_coord(span);
                d = pick_coord(span);
                // mostly ordered bounds, sometimes left reversed
                if ($urandom_range(0, 9) != 0) begin
                    if (a > b) begin
                        a ^= b;
                        b ^= a;
                        a ^= b;
                    end
                    if (c > d) begin
                        c ^= d;
                        d ^= c;
                        c ^= d;
                    end
                end
                queue_item(rst2d_pkg::KIND_QUERY, a, c, b, d, $urandom, n % 300 == 0);
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || in_flight)
            @(posedge aclk);
        while (pending_sums.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (pending_sums.size() != 0)
            fail_count++;
        if (fail_count == 0) begin
            $display("range_sum_tree_2d_unit_tb OK");
        end else begin
            $display("range_sum_tree_2d_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
